[hdl/urm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types, register map and constants of the ultrasonic range block.
// ----------------------------------------------------------------------------
package urm_pkg;

  // Default counter width for tick and interval counters.
  localparam int COUNT_WIDTH_DEF = 20;

  // Field widths.
  localparam int TEMP_W     = 12;
  localparam int DIST_W     = 16;
  localparam int TIMEOUT_W  = 20;
  // Signed width of the Q20 sound speed and of the first multiplier operand.
  localparam int VEL_W      = 22;
  // The halving plus the Q20 scaling of the distance product.
  localparam int DIST_SHIFT = 21;

  // Configuration port.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TRIGGER_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASE_VEL     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_COEF    = 3'd5;

  // Register reset values.
  localparam logic [9:0]  RST_RESET_LOW    = 10'd2;
  localparam logic [9:0]  RST_TRIGGER_HIGH = 10'd10;
  localparam logic [19:0] RST_ECHO_TIMEOUT = 20'd30000;
  localparam logic [15:0] RST_MAX_RANGE    = 16'd4000;
  localparam logic [15:0] RST_BASE_VEL     = 16'd21712;
  localparam logic [7:0]  RST_TEMP_COEF    = 8'd40;

  // Configuration register set.
  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [9:0]  trigger_high_us;
    logic [19:0] echo_timeout_us;
    logic [15:0] max_range_mm;
    logic [15:0] base_velocity_q16;
    logic [7:0]  temp_coef_q16;
  } cfg_t;

  // Measurement phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

  // Sequencer steps around the shared multiplier.
  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'd0,
    SEQ_MUL_T = 3'd1,
    SEQ_ADD_V = 3'd2,
    SEQ_MUL_D = 3'd3,
    SEQ_CLAMP = 3'd4,
    SEQ_OUT   = 3'd5
  } seq_t;

  // Status flags of one result beat.
  typedef struct packed {
    logic trigger_level;
    logic busy_res;
    logic done_res;
    logic timed_out;
  } res_flags_t;

endpackage
`default_nettype wire

[hdl/urm_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_regs
// APB-style configuration register file with read back.
// ----------------------------------------------------------------------------
module urm_regs (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_psel,
  input  wire                             cfg_penable,
  input  wire                             cfg_pwrite,
  input  wire  [urm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [urm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [urm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output urm_pkg::cfg_t                   cfg
);

  urm_pkg::cfg_t                  cfg_r;
  urm_pkg::cfg_t                  cfg_nxt;
  logic [urm_pkg::REG_IDX_W-1:0]  idx;
  logic                           wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[urm_pkg::CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // Write decode; indexes past the register list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        urm_pkg::REG_RESET_LOW:    cfg_nxt.reset_low_us      = cfg_pwdata[9:0];
        urm_pkg::REG_TRIGGER_HIGH: cfg_nxt.trigger_high_us   = cfg_pwdata[9:0];
        urm_pkg::REG_ECHO_TIMEOUT: cfg_nxt.echo_timeout_us   = cfg_pwdata[19:0];
        urm_pkg::REG_MAX_RANGE:    cfg_nxt.max_range_mm      = cfg_pwdata[15:0];
        urm_pkg::REG_BASE_VEL:     cfg_nxt.base_velocity_q16 = cfg_pwdata[15:0];
        urm_pkg::REG_TEMP_COEF:    cfg_nxt.temp_coef_q16     = cfg_pwdata[7:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us      <= urm_pkg::RST_RESET_LOW;
      cfg_r.trigger_high_us   <= urm_pkg::RST_TRIGGER_HIGH;
      cfg_r.echo_timeout_us   <= urm_pkg::RST_ECHO_TIMEOUT;
      cfg_r.max_range_mm      <= urm_pkg::RST_MAX_RANGE;
      cfg_r.base_velocity_q16 <= urm_pkg::RST_BASE_VEL;
      cfg_r.temp_coef_q16     <= urm_pkg::RST_TEMP_COEF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      urm_pkg::REG_RESET_LOW:    cfg_prdata = 32'(cfg_r.reset_low_us);
      urm_pkg::REG_TRIGGER_HIGH: cfg_prdata = 32'(cfg_r.trigger_high_us);
      urm_pkg::REG_ECHO_TIMEOUT: cfg_prdata = 32'(cfg_r.echo_timeout_us);
      urm_pkg::REG_MAX_RANGE:    cfg_prdata = 32'(cfg_r.max_range_mm);
      urm_pkg::REG_BASE_VEL:     cfg_prdata = 32'(cfg_r.base_velocity_q16);
      urm_pkg::REG_TEMP_COEF:    cfg_prdata = 32'(cfg_r.temp_coef_q16);
      default:                   cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[hdl/urm_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module urm_mul #(
  parameter int A_W = 22,
  parameter int B_W = 21
) (
  input  wire                         clk,
  input  wire                         en,
  input  wire  signed [A_W-1:0]       op_a,
  input  wire  signed [B_W-1:0]       op_b,
  output logic signed [A_W+B_W-1:0]   prod
);

  logic signed [A_W+B_W-1:0] prod_r;

  // The product is captured only when the sequencer issues an operation.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

[hdl/urm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_ctrl
// Ranging phase logic, distance sequencer and output beat register.
// ----------------------------------------------------------------------------
module urm_ctrl #(
  parameter int COUNT_WIDTH = urm_pkg::COUNT_WIDTH_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  urm_pkg::cfg_t                              cfg,
  input  wire                                        in_tvalid,
  output logic                                       in_tready,
  input  wire                                        in_func,
  input  wire  signed [urm_pkg::TEMP_W-1:0]          in_temperature,
  input  wire                                        in_echo_level,
  output logic                                       out_tvalid,
  input  wire                                        out_tready,
  output urm_pkg::res_flags_t                        out_flags,
  output logic [urm_pkg::DIST_W-1:0]                 out_distance_mm,
  output logic                                       mul_en,
  output logic signed [urm_pkg::VEL_W-1:0]           mul_a,
  output logic signed [COUNT_WIDTH:0]                mul_b,
  input  wire  signed [urm_pkg::VEL_W+COUNT_WIDTH:0] mul_prod
);

  localparam int CW    = COUNT_WIDTH;
  localparam int B_W   = CW + 1;
  localparam int CMP_W = (CW > urm_pkg::TIMEOUT_W) ? CW : urm_pkg::TIMEOUT_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  // Ranging state.
  urm_pkg::phase_t                    phase_r, phase_nxt;
  logic [CW-1:0]                      tick_r, tick_nxt;
  logic                               echo_prev_r, echo_prev_nxt;
  logic [CW-1:0]                      interval_r, interval_nxt;
  logic signed [urm_pkg::TEMP_W-1:0]  temp_r, temp_nxt;

  // Sequencer and working registers.
  urm_pkg::seq_t                      seq_r, seq_nxt;
  urm_pkg::res_flags_t                flags_r, flags_nxt;
  logic [urm_pkg::VEL_W-2:0]          vel_r, vel_nxt;
  logic [urm_pkg::DIST_W-1:0]         dist_r, dist_nxt;

  // Output beat register.
  logic                               out_valid_r, out_valid_nxt;
  urm_pkg::res_flags_t                out_flags_r, out_flags_nxt;
  logic [urm_pkg::DIST_W-1:0]         out_dist_r, out_dist_nxt;

  logic [CW-1:0]                      cnt_inc;
  logic signed [urm_pkg::VEL_W-1:0]   vel_sum;
  logic [CW-1:0]                      dist_raw;
  logic                               fin;
  logic                               tmo;

  assign in_tready       = (seq_r == urm_pkg::SEQ_IDLE);
  assign out_tvalid      = out_valid_r;
  assign out_flags       = out_flags_r;
  assign out_distance_mm = out_dist_r;

  // Saturating tick increment.
  assign cnt_inc = (tick_r == CNT_MAX) ? tick_r : tick_r + 1'b1;

  // Sound speed in Q20: base * 16 plus the coefficient product.
  assign vel_sum = $signed(urm_pkg::VEL_W'({cfg.base_velocity_q16, 4'b0000}))
                 + $signed(mul_prod[urm_pkg::VEL_W-1:0]);

  // Distance before clamping: the product shifted down by the Q20 scale and halving.
  assign dist_raw = mul_prod[urm_pkg::DIST_SHIFT +: CW];

  // Phase update, sequencer and output loading.
  always_comb begin
    fin           = 1'b0;
    tmo           = 1'b0;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    echo_prev_nxt = echo_prev_r;
    interval_nxt  = interval_r;
    temp_nxt      = temp_r;
    seq_nxt       = seq_r;
    flags_nxt     = flags_r;
    vel_nxt       = vel_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_flags_nxt = out_flags_r;
    out_dist_nxt  = out_dist_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (seq_r)
      urm_pkg::SEQ_IDLE: begin
        if (in_tvalid) begin
          if (in_func) begin
            // A start while busy is ignored.
            if (phase_r == urm_pkg::PH_IDLE) begin
              temp_nxt  = in_temperature;
              tick_nxt  = '0;
              phase_nxt = (cfg.reset_low_us == '0) ? urm_pkg::PH_HIGH : urm_pkg::PH_LOW;
            end
          end else if (phase_r != urm_pkg::PH_IDLE) begin
            tick_nxt = cnt_inc;
            case (phase_r)
              urm_pkg::PH_LOW: begin
                if (CMP_W'(cnt_inc) >= CMP_W'(cfg.reset_low_us)) begin
                  phase_nxt = urm_pkg::PH_HIGH;
                  tick_nxt  = '0;
                end
              end
              urm_pkg::PH_HIGH: begin
                if (CMP_W'(cnt_inc) >= CMP_W'(cfg.trigger_high_us)) begin
                  phase_nxt = urm_pkg::PH_WAIT;
                  tick_nxt  = '0;
                end
              end
              default: begin
                // The falling echo edge wins over the timeout.
                if (echo_prev_r && !in_echo_level) begin
                  interval_nxt = cnt_inc;
                  fin          = 1'b1;
                end else if ((CMP_W'(cnt_inc) >= CMP_W'(cfg.echo_timeout_us)) ||
                             (cnt_inc == CNT_MAX)) begin
                  fin = 1'b1;
                  tmo = 1'b1;
                end
                if (fin) begin
                  phase_nxt = urm_pkg::PH_IDLE;
                  tick_nxt  = '0;
                end
              end
            endcase
          end
          echo_prev_nxt           = in_echo_level;
          flags_nxt.trigger_level = (phase_nxt == urm_pkg::PH_HIGH);
          flags_nxt.busy_res      = (phase_nxt != urm_pkg::PH_IDLE);
          flags_nxt.done_res      = fin;
          flags_nxt.timed_out     = tmo;
          dist_nxt                = '0;
          seq_nxt                 = fin ? urm_pkg::SEQ_MUL_T : urm_pkg::SEQ_OUT;
        end
      end
      urm_pkg::SEQ_MUL_T: begin
        // Coefficient times the held temperature.
        mul_en  = 1'b1;
        mul_a   = $signed(urm_pkg::VEL_W'(cfg.temp_coef_q16));
        mul_b   = B_W'(temp_r);
        seq_nxt = urm_pkg::SEQ_ADD_V;
      end
      urm_pkg::SEQ_ADD_V: begin
        // A negative speed is taken as zero.
        vel_nxt = vel_sum[urm_pkg::VEL_W-1] ? '0 : vel_sum[urm_pkg::VEL_W-2:0];
        seq_nxt = urm_pkg::SEQ_MUL_D;
      end
      urm_pkg::SEQ_MUL_D: begin
        // Speed times the stored interval.
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, vel_r});
        mul_b   = $signed({1'b0, interval_r});
        seq_nxt = urm_pkg::SEQ_CLAMP;
      end
      urm_pkg::SEQ_CLAMP: begin
        if (CMP_W'(dist_raw) > CMP_W'(cfg.max_range_mm)) begin
          dist_nxt = cfg.max_range_mm;
        end else begin
          dist_nxt = urm_pkg::DIST_W'(dist_raw);
        end
        seq_nxt = urm_pkg::SEQ_OUT;
      end
      urm_pkg::SEQ_OUT: begin
        // Load the beat once the output register is free or being taken.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_flags_nxt = flags_r;
          out_dist_nxt  = dist_r;
          seq_nxt       = urm_pkg::SEQ_IDLE;
        end
      end
      default: begin
        seq_nxt = urm_pkg::SEQ_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= urm_pkg::PH_IDLE;
      tick_r      <= '0;
      echo_prev_r <= 1'b0;
      interval_r  <= '0;
      temp_r      <= '0;
      seq_r       <= urm_pkg::SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      echo_prev_r <= echo_prev_nxt;
      interval_r  <= interval_nxt;
      temp_r      <= temp_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    flags_r     <= flags_nxt;
    vel_r       <= vel_nxt;
    dist_r      <= dist_nxt;
    out_flags_r <= out_flags_nxt;
    out_dist_r  <= out_dist_nxt;
  end

`ifndef ASSERT_OFF
  // A finishing beat never reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.done_res |-> !out_flags_r.busy_res)
    else $error("done beat reports busy");

  // Without done, the timeout flag and the distance are zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_flags_r.done_res |-> !out_flags_r.timed_out && out_dist_r == '0)
    else $error("fields set on a beat without done");

  // The trigger is high only while busy.
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.trigger_level |-> out_flags_r.busy_res)
    else $error("trigger high outside a measurement");

  // The distance steps run in fixed order after the first multiply.
  a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == urm_pkg::SEQ_MUL_T |=> seq_r == urm_pkg::SEQ_ADD_V ##1
      seq_r == urm_pkg::SEQ_MUL_D ##1 seq_r == urm_pkg::SEQ_CLAMP)
    else $error("distance sequence out of order");

  // The phase only changes when an input beat is accepted.
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) |=> $stable(phase_r))
    else $error("phase changed without an input beat");
`endif

endmodule
`default_nettype wire

[hdl/ultrasonic_range_measure.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_range_measure
// Sonar ranging controller stepped by microsecond tick beats, with a
// temperature-compensated distance computed on a shared multiplier.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Contents
//  in_      slave      in_tvalid / in_tready     tick or start, temperature, echo
//  out_     master     out_tvalid / out_tready   trigger, status, distance
//  cfg_     APB slave  psel, penable, pready     six configuration registers
//
//  A tick or start beat that does not finish a measurement goes straight to the
//  output step. A finishing beat first makes two passes through the shared
//  multiplier (speed, then distance), with one add and one clamp step.
//  Synchronous active-low reset returns to idle with the register defaults.
//  A stalled output holds the sequencer in its output step; input is not
//  accepted until the pending beat is loaded into the output register.
// ----------------------------------------------------------------------------
module ultrasonic_range_measure #(
  parameter int COUNT_WIDTH = urm_pkg::COUNT_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // Input channel.
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [15:0]                     in_tdata,   // [11:0] temperature, [12] echo_level
  input  wire                             in_tuser,   // [0] func
  // Result channel.
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [23:0]                     out_tdata,  // [0] trigger_level, [1] busy_res,
                                                      // [2] done_res, [3] timed_out,
                                                      // [19:4] distance_mm
  // Configuration port.
  input  wire                             cfg_psel,
  input  wire                             cfg_penable,
  input  wire                             cfg_pwrite,
  input  wire  [urm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [urm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [urm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int PW = urm_pkg::VEL_W + COUNT_WIDTH + 1;

  urm_pkg::cfg_t                     cfg;
  urm_pkg::res_flags_t               flags;
  logic [urm_pkg::DIST_W-1:0]        dist_mm;
  logic                              mul_en;
  logic signed [urm_pkg::VEL_W-1:0]  mul_a;
  logic signed [COUNT_WIDTH:0]       mul_b;
  logic signed [PW-1:0]              mul_prod;

  urm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  urm_mul #(
    .A_W (urm_pkg::VEL_W),
    .B_W (COUNT_WIDTH + 1)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  urm_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_func         (in_tuser),
    .in_temperature  ($signed(in_tdata[urm_pkg::TEMP_W-1:0])),
    .in_echo_level   (in_tdata[urm_pkg::TEMP_W]),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_flags       (flags),
    .out_distance_mm (dist_mm),
    .mul_en          (mul_en),
    .mul_a           (mul_a),
    .mul_b           (mul_b),
    .mul_prod        (mul_prod)
  );

  // Pack the result beat, first field in the lowest bit.
  assign out_tdata = {4'b0000, dist_mm, flags.timed_out, flags.done_res,
                      flags.busy_res, flags.trigger_level};

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ultrasonic range block. Tick and start beats are
// streamed in with random gaps while the result side stalls at random. A
// ranging tracker follows the trigger, echo and timeout sequencing together
// with the compensated distance math, and checks every result beat in order.
// The run steps through several register settings, both extremes included.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 400;
  localparam longint unsigned TICK_MAX = (64'd1 << urm_pkg::COUNT_WIDTH_DEF) - 1;

  // Fields of one result beat as the tracker expects them.
  typedef struct {
    bit          trigger_level;
    bit          busy_res;
    bit          done_res;
    bit          timed_out;
    logic [15:0] distance_mm;
  } status_beat_t;

  // Tracks the measurement sequence and holds the expected result beats.
  class ranging_tracker;
    urm_pkg::cfg_t                     regs;
    urm_pkg::phase_t                   phase;
    longint unsigned                   ticks;
    bit                                echo_prev;
    longint unsigned                   interval_us;
    logic signed [urm_pkg::TEMP_W-1:0] held_temp;
    status_beat_t                      expected_status[$];
    int                                errors;
    int                                checked;

    function new();
      regs.reset_low_us      = urm_pkg::RST_RESET_LOW;
      regs.trigger_high_us   = urm_pkg::RST_TRIGGER_HIGH;
      regs.echo_timeout_us   = urm_pkg::RST_ECHO_TIMEOUT;
      regs.max_range_mm      = urm_pkg::RST_MAX_RANGE;
      regs.base_velocity_q16 = urm_pkg::RST_BASE_VEL;
      regs.temp_coef_q16     = urm_pkg::RST_TEMP_COEF;
      phase       = urm_pkg::PH_IDLE;
      ticks       = 0;
      echo_prev   = 1'b0;
      interval_us = 0;
      held_temp   = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void write_reg(input logic [urm_pkg::REG_IDX_W-1:0] idx,
                            input logic [31:0] value);
      case (idx)
        urm_pkg::REG_RESET_LOW:    regs.reset_low_us      = value[9:0];
        urm_pkg::REG_TRIGGER_HIGH: regs.trigger_high_us   = value[9:0];
        urm_pkg::REG_ECHO_TIMEOUT: regs.echo_timeout_us   = value[19:0];
        urm_pkg::REG_MAX_RANGE:    regs.max_range_mm      = value[15:0];
        urm_pkg::REG_BASE_VEL:     regs.base_velocity_q16 = value[15:0];
        urm_pkg::REG_TEMP_COEF:    regs.temp_coef_q16     = value[7:0];
        default: ;
      endcase
    endfunction

    // Sound speed in Q20 mm/us times the stored interval, halved, clamped.
    function logic [15:0] distance_for();
      longint speed;
      longint range_mm;
      speed = longint'(regs.base_velocity_q16) * 16
              + longint'(regs.temp_coef_q16) * longint'(held_temp);
      if (speed < 0) speed = 0;
      range_mm = (speed * longint'(interval_us)) >>> urm_pkg::DIST_SHIFT;
      if (range_mm > longint'(regs.max_range_mm)) range_mm = longint'(regs.max_range_mm);
      return range_mm[15:0];
    endfunction

    function void note_beat(input bit start, input logic [11:0] temp, input bit echo);
      status_beat_t r;
      r = '{default: '0};
      if (start) begin
        // A start only counts when no measurement is running.
        if (phase == urm_pkg::PH_IDLE) begin
          held_temp = temp;
          ticks     = 0;
          phase     = (regs.reset_low_us == 0) ? urm_pkg::PH_HIGH : urm_pkg::PH_LOW;
        end
      end else if (phase != urm_pkg::PH_IDLE) begin
        if (ticks < TICK_MAX) ticks++;
        case (phase)
          urm_pkg::PH_LOW: begin
            if (ticks >= regs.reset_low_us) begin
              phase = urm_pkg::PH_HIGH;
              ticks = 0;
            end
          end
          urm_pkg::PH_HIGH: begin
            if (ticks >= regs.trigger_high_us) begin
              phase = urm_pkg::PH_WAIT;
              ticks = 0;
            end
          end
          default: begin
            // A falling echo takes priority over the timeout on the same tick.
            if (echo_prev && !echo) begin
              interval_us = ticks;
              r.done_res  = 1'b1;
            end else if (ticks >= regs.echo_timeout_us || ticks == TICK_MAX) begin
              r.done_res  = 1'b1;
              r.timed_out = 1'b1;
            end
            if (r.done_res) begin
              r.distance_mm = distance_for();
              phase = urm_pkg::PH_IDLE;
              ticks = 0;
            end
          end
        endcase
      end
      echo_prev       = echo;
      r.trigger_level = (phase == urm_pkg::PH_HIGH);
      r.busy_res      = (phase != urm_pkg::PH_IDLE);
      expected_status.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH %s", msg);
    endtask

    task compare(input string field, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %0d, expected %0d", checked, field, got, want));
    endtask

    task check_beat(input logic [23:0] data);
      status_beat_t e;
      checked++;
      if (expected_status.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing expected", checked));
        return;
      end
      e = expected_status.pop_front();
      compare("trigger_level", 16'(data[0]), 16'(e.trigger_level));
      compare("busy_res", 16'(data[1]), 16'(e.busy_res));
      compare("done_res", 16'(data[2]), 16'(e.done_res));
      compare("timed_out", 16'(data[3]), 16'(e.timed_out));
      compare("distance_mm", data[19:4], e.distance_mm);
    endtask
  endclass

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [15:0]                    in_tdata    = '0;  // [11:0] temperature, [12] echo_level
  logic                           in_tuser    = 1'b0; // [0] func
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [23:0]                    out_tdata;  // [0] trigger_level, [1] busy_res,
                                              // [2] done_res, [3] timed_out,
                                              // [19:4] distance_mm
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [urm_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [urm_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [urm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  ranging_tracker range_track = new();
  bit  idle_on       = 1'b1;
  bit  stall_request = 1'b0;
  int  hold_left     = 0;
  int  beats_in      = 0;
  int  cycle_count   = 0;

  ultrasonic_range_measure dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall bursts, plus one long hold on request.
  always @(posedge clk) begin
    if (stall_request) begin
      stall_request <= 1'b0;
      hold_left     <= LONG_HOLD;
      out_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      hold_left  <= int'($urandom_range(0, 15));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) range_track.check_beat(out_tdata);
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one beat and waits until it is taken.
  task automatic send_item(input bit start, input logic [11:0] temp, input bit echo);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= start;
    in_tdata  <= {3'b000, echo, temp};
    do @(posedge clk); while (!in_tready);
    range_track.note_beat(start, temp, echo);
    beats_in++;
  endtask

  // Stops the input and lets every outstanding result come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (range_track.expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [urm_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    range_track.write_reg(idx, value);
    @(posedge clk);
  endtask

  // Half the writes carry random bits above the register width.
  function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 1) == 0) return value;
    return value | (junk << width);
  endfunction

  task automatic set_config(input logic [9:0] low, input logic [9:0] high,
                            input logic [19:0] timeout, input logic [15:0] max_mm,
                            input logic [15:0] base, input logic [7:0] coef);
    drain();
    write_reg(urm_pkg::REG_RESET_LOW, with_junk(32'(low), 10));
    write_reg(urm_pkg::REG_TRIGGER_HIGH, with_junk(32'(high), 10));
    write_reg(urm_pkg::REG_ECHO_TIMEOUT, with_junk(32'(timeout), 20));
    write_reg(urm_pkg::REG_MAX_RANGE, with_junk(32'(max_mm), 16));
    write_reg(urm_pkg::REG_BASE_VEL, with_junk(32'(base), 16));
    write_reg(urm_pkg::REG_TEMP_COEF, with_junk(32'(coef), 8));
  endtask

  // One well-formed measurement: start, trigger ticks, an echo pulse, idle ticks.
  task automatic measure(input int pulse_cap);
    int lead;
    int pulse;
    lead = int'(range_track.regs.reset_low_us) - 1 + int'($urandom_range(0, 2))
           + ((range_track.regs.trigger_high_us == 0) ? 1
                                                       : int'(range_track.regs.trigger_high_us));
    pulse = int'($urandom_range(1, pulse_cap));
    send_item(1'b1, 12'($urandom), 1'b0);
    if ($urandom_range(0, 7) == 0) send_item(1'b1, 12'($urandom), 1'b0);
    repeat (lead) send_item(1'b0, 12'($urandom), $urandom_range(0, 15) == 0);
    repeat (pulse) send_item(1'b0, 12'($urandom), 1'b1);
    repeat ($urandom_range(1, 3)) send_item(1'b0, 12'($urandom), 1'b0);
  endtask

  // Mostly measurements, with short bursts of arbitrary beats in between.
  task automatic run_phase(input int budget);
    int stop_at;
    int cap;
    stop_at = beats_in + budget;
    cap = (range_track.regs.echo_timeout_us > 148) ? 150
                                                   : int'(range_track.regs.echo_timeout_us) + 2;
    while (beats_in < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), 12'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        measure(cap);
      end
    end
  endtask

  task automatic random_config();
    set_config(10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
               20'($urandom_range(1, 120)),
               $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                    : 16'($urandom_range(0, 60)),
               16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no low time, no high time, a timeout of three ticks, fastest speed.
    set_config(10'd0, 10'd0, 20'd3, 16'hFFFF, 16'hFFFF, 8'hFF);
    // A tick while idle changes nothing.
    send_item(1'b0, 12'h7FF, 1'b1);
    // Hottest start goes straight to the trigger pulse.
    send_item(1'b1, 12'h7FF, 1'b1);
    // A second start while busy is ignored.
    send_item(1'b1, 12'h800, 1'b1);
    // The pulse with zero high time still lasts one tick.
    send_item(1'b0, 12'h000, 1'b1);
    send_item(1'b0, 12'hABC, 1'b1);
    send_item(1'b0, 12'h543, 1'b1);
    // The echo falls on the tick where the timeout expires; the edge wins.
    send_item(1'b0, 12'h000, 1'b0);
    // Coldest start with no echo: the timeout reuses the stored interval.
    send_item(1'b1, 12'h800, 1'b0);
    repeat (4) send_item(1'b0, 12'hFFF, 1'b0);
    // The echo falls on the first counted tick.
    send_item(1'b1, 12'hFFF, 1'b1);
    send_item(1'b0, 12'h000, 1'b1);
    send_item(1'b0, 12'hFFF, 1'b0);
    // Idle ticks after the measurement.
    send_item(1'b0, 12'h555, 1'b0);
    send_item(1'b0, 12'hAAA, 1'b1);

    // Register defaults.
    set_config(urm_pkg::RST_RESET_LOW, urm_pkg::RST_TRIGGER_HIGH,
               urm_pkg::RST_ECHO_TIMEOUT, urm_pkg::RST_MAX_RANGE,
               urm_pkg::RST_BASE_VEL, urm_pkg::RST_TEMP_COEF);
    run_phase(180);

    // Shortest timeout, zero ceiling, zero speed.
    set_config(10'd0, 10'd1, 20'd1, 16'd0, 16'd0, 8'd0);
    run_phase(80);

    // Negative temperatures drive the speed below zero; the result side
    // holds off for a long stretch so the input backs up.
    set_config(10'd1, 10'd2, 20'd40, 16'hFFFF, 16'd0, 8'hFF);
    stall_request <= 1'b1;
    run_phase(150);

    // Longest trigger pulse and timeout, one measurement.
    set_config(10'd1, 10'd1023, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    measure(20);

    repeat (3) begin
      random_config();
      run_phase(60);
    end

    // Closing stretch without any idling.
    random_config();
    idle_on = 1'b0;
    run_phase(120);

    drain();
    if (range_track.errors == 0 && range_track.expected_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
